>>> hdl/fpst_pkg.sv
// ----------------------------------------------------------------------------
// Fenwick prefix-sum table package
// Shared widths, request and status codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package fpst_pkg;

	localparam int SIZE_W  = 11;
	localparam int POS_W   = 10;
	localparam int DATA_W  = 32;
	localparam int STAT_W  = 2;
	localparam int WALK_W  = 12;
	localparam int SIZE_RESET = 1024;

	typedef enum logic {
		REQ_ADD   = 1'b0,
		REQ_QUERY = 1'b1
	} req_type_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_BAD_POS   = 2'd1,
		STAT_BAD_RANGE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADD,
		ST_QUERY,
		ST_DONE
	} seq_state_t;

endpackage

>>> hdl/fpst_if.sv
// ----------------------------------------------------------------------------
// Fenwick prefix-sum table channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface fpst_req_if;
	logic                         valid;
	logic                         ready;
	logic                         req_type;
	logic [fpst_pkg::POS_W-1:0]   position;
	logic [fpst_pkg::DATA_W-1:0]  value;
	logic [fpst_pkg::SIZE_W-1:0]  range_left;
	logic [fpst_pkg::SIZE_W-1:0]  range_right;

	modport source (output valid, req_type, position, value, range_left, range_right,
		input ready);
	modport sink (input valid, req_type, position, value, range_left, range_right,
		output ready);
endinterface

interface fpst_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [fpst_pkg::DATA_W-1:0]  range_sum;
	logic [fpst_pkg::STAT_W-1:0]  status;

	modport source (output valid, range_sum, status, input ready);
	modport sink (input valid, range_sum, status, output ready);
endinterface

>>> hdl/fpst_ram.sv
// ----------------------------------------------------------------------------
// Fenwick prefix-sum table cell memory
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module fpst_ram #(
	parameter int DEPTH  = 1024,
	parameter int WIDTH  = 32,
	parameter int ADDR_W = 10
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> hdl/fpst_seq.sv
// ----------------------------------------------------------------------------
// Fenwick prefix-sum table sequencer
// Checks each request, walks the index chains through the cell memory with
// read-modify-write for adds and accumulation for range sums, and holds the
// response register. Also sweeps the memory to zero after reset and on request.
// ----------------------------------------------------------------------------
module fpst_seq #(
	parameter int MAX_CELLS   = 1024,
	parameter int VALUE_WIDTH = 32,
	parameter int ADDR_W      = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clr_start,
	input  logic [fpst_pkg::SIZE_W-1:0]   size,
	fpst_req_if.sink                      req,
	fpst_rsp_if.source                    rsp,
	output logic                          wr_en,
	output logic [ADDR_W-1:0]             wr_addr,
	output logic [VALUE_WIDTH-1:0]        wr_data,
	output logic                          rd_en,
	output logic [ADDR_W-1:0]             rd_addr,
	input  logic [VALUE_WIDTH-1:0]        rd_data
);

	localparam int WW = fpst_pkg::WALK_W;
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_CELLS - 1);

	fpst_pkg::seq_state_t state_q, state_d;

	logic [WW-1:0]                   idx_q, idx_d;
	logic                            phase_q, phase_d;
	logic [fpst_pkg::SIZE_W-1:0]     left_q, left_d;
	logic [VALUE_WIDTH-1:0]          val_q, val_d;
	logic [VALUE_WIDTH-1:0]          acc_q, acc_d;
	fpst_pkg::status_t               stat_q, stat_d;
	logic [ADDR_W-1:0]               clr_q, clr_d;

	logic                            pending_s1;
	logic                            neg_s1;
	logic [ADDR_W-1:0]               addr_s1;

	logic                            out_valid_q;
	logic [fpst_pkg::DATA_W-1:0]     out_sum_q;
	fpst_pkg::status_t               out_stat_q;

	logic                            issue;
	logic                            slot_free;
	logic                            load_out;
	logic [WW-1:0]                   lsb;
	logic [WW-1:0]                   size_w;
	logic [31:0]                     idx_m1;
	logic                            bad_pos;
	logic                            bad_range;

	assign lsb       = idx_q & (~idx_q + WW'(1));
	assign size_w    = WW'(size);
	assign idx_m1    = 32'(idx_q - WW'(1));
	assign slot_free = !out_valid_q || rsp.ready;
	assign bad_pos   = {1'b0, req.position} >= size;
	assign bad_range = (req.range_left > req.range_right) || (req.range_right > size);

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		phase_d   = phase_q;
		left_d    = left_q;
		val_d     = val_q;
		acc_d     = acc_q;
		stat_d    = stat_q;
		clr_d     = clr_q;
		issue     = 1'b0;
		load_out  = 1'b0;
		req.ready = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = addr_s1;
		wr_data   = rd_data + val_q;

		if (pending_s1 && state_q == fpst_pkg::ST_QUERY) begin
			acc_d = neg_s1 ? acc_q - rd_data : acc_q + rd_data;
		end

		unique case (state_q)
			fpst_pkg::ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
				clr_d   = clr_q + ADDR_W'(1);
				if (clr_q == LAST_ADDR) begin
					state_d = fpst_pkg::ST_IDLE;
				end
			end
			fpst_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					acc_d   = '0;
					phase_d = 1'b0;
					val_d   = VALUE_WIDTH'(req.value);
					left_d  = req.range_left;
					stat_d  = fpst_pkg::STAT_OK;
					if (req.req_type == fpst_pkg::REQ_ADD) begin
						idx_d = WW'(req.position) + WW'(1);
						if (bad_pos) begin
							stat_d  = fpst_pkg::STAT_BAD_POS;
							state_d = fpst_pkg::ST_DONE;
						end else begin
							state_d = fpst_pkg::ST_ADD;
						end
					end else begin
						idx_d = WW'(req.range_right);
						if (bad_range) begin
							stat_d  = fpst_pkg::STAT_BAD_RANGE;
							state_d = fpst_pkg::ST_DONE;
						end else begin
							state_d = fpst_pkg::ST_QUERY;
						end
					end
				end
			end
			fpst_pkg::ST_ADD: begin
				wr_en = pending_s1;
				issue = idx_q <= size_w;
				if (issue) begin
					idx_d = idx_q + lsb;
				end else if (!pending_s1) begin
					state_d = fpst_pkg::ST_DONE;
				end
			end
			fpst_pkg::ST_QUERY: begin
				issue = idx_q != '0;
				if (issue) begin
					idx_d = idx_q - lsb;
				end else if (!phase_q) begin
					idx_d   = WW'(left_q);
					phase_d = 1'b1;
				end else if (!pending_s1) begin
					state_d = fpst_pkg::ST_DONE;
				end
			end
			fpst_pkg::ST_DONE: begin
				if (slot_free) begin
					load_out = 1'b1;
					state_d  = fpst_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fpst_pkg::ST_IDLE;
			end
		endcase

		if (clr_start) begin
			state_d = fpst_pkg::ST_CLEAR;
			clr_d   = '0;
		end
	end

	assign rd_en   = issue;
	assign rd_addr = idx_m1[ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fpst_pkg::ST_CLEAR;
			clr_q       <= '0;
			pending_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			clr_q      <= clr_d;
			pending_s1 <= issue;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q   <= idx_d;
		phase_q <= phase_d;
		left_q  <= left_d;
		val_q   <= val_d;
		acc_q   <= acc_d;
		stat_q  <= stat_d;
		neg_s1  <= phase_q;
		addr_s1 <= idx_m1[ADDR_W-1:0];
		if (load_out) begin
			out_sum_q  <= fpst_pkg::DATA_W'(acc_q);
			out_stat_q <= stat_q;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.range_sum = out_sum_q;
	assign rsp.status    = out_stat_q;

endmodule

>>> hdl/fenwick_prefix_sum_table_top.sv
// ----------------------------------------------------------------------------
// Fenwick prefix-sum table
// Binary indexed tree in one cell memory: point adds and range sums.
//
//   Channel   Direction  Handshake          Payload
//   req       in         valid/ready        req_type, position, value,
//                                           range_left, range_right
//   rsp       out        valid/ready        range_sum, status
//   cfg       in         cfg_wr_en          cfg_wr_data (size_in_use)
//
// One request is in flight; the next is taken while a result waits. An add
// walks L chain steps and a range sum Lr + Ll steps, with L, Lr, Ll the chain
// lengths and one memory read per step; a rejected request goes straight to
// the done state without a memory read. A new result stalls until the
// response register frees. After reset and each size write, a clearing pass
// writes zero to all MAX_CELLS cells while no request is taken.
// ----------------------------------------------------------------------------
module fenwick_prefix_sum_table_top #(
	parameter int MAX_CELLS   = 1024,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [fpst_pkg::SIZE_W-1:0] cfg_wr_data,
	fpst_req_if.sink                    req,
	fpst_rsp_if.source                  rsp
);

	localparam int ADDR_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam int SIZE_INIT = (fpst_pkg::SIZE_RESET > MAX_CELLS) ?
		MAX_CELLS : fpst_pkg::SIZE_RESET;

	logic [fpst_pkg::SIZE_W-1:0] size_q;
	logic                        wr_en;
	logic [ADDR_W-1:0]           wr_addr;
	logic [VALUE_WIDTH-1:0]      wr_data;
	logic                        rd_en;
	logic [ADDR_W-1:0]           rd_addr;
	logic [VALUE_WIDTH-1:0]      rd_data;

	// Sizes above the memory depth saturate to the depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= fpst_pkg::SIZE_W'(SIZE_INIT);
		end else if (cfg_wr_en) begin
			if (32'(cfg_wr_data) > 32'(MAX_CELLS)) begin
				size_q <= fpst_pkg::SIZE_W'(MAX_CELLS);
			end else begin
				size_q <= cfg_wr_data;
			end
		end
	end

	fpst_seq #(
		.MAX_CELLS   (MAX_CELLS),
		.VALUE_WIDTH (VALUE_WIDTH),
		.ADDR_W      (ADDR_W)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.clr_start (cfg_wr_en),
		.size      (size_q),
		.req       (req),
		.rsp       (rsp),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data)
	);

	fpst_ram #(
		.DEPTH  (MAX_CELLS),
		.WIDTH  (VALUE_WIDTH),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule
